// ===== src/jmmc_pkg.sv =====
// Shared types, register map, command codes and reset values for the
// joystick manual-mode controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jmmc_pkg;

    localparam int BUTTON_COUNT_DEF = 5;
    localparam int CMD_BUTTONS      = 5;
    localparam int SAMPLE_BITS      = 12;

    localparam int BTN_A = 0;
    localparam int BTN_B = 1;
    localparam int BTN_C = 2;
    localparam int BTN_D = 3;
    localparam int BTN_K = 4;

    localparam int ADDR_BITS   = 5;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    localparam logic [11:0] SAMPLE_MASK =
        (SAMPLE_BITS >= 12) ? 12'hFFF : 12'((1 << SAMPLE_BITS) - 1);

    typedef enum logic [2:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_ADC_LOW   = 3'd1,
        REG_ADC_HIGH  = 3'd2,
        REG_FREE_DUTY = 3'd3,
        REG_STEP_SIZE = 3'd4
    } reg_index_t;

    localparam logic [1:0] HOME_NONE   = 2'd0;
    localparam logic [1:0] HOME_SENSOR = 2'd1;
    localparam logic [1:0] HOME_SET    = 2'd2;
    localparam logic [1:0] GRIP_PICK   = 2'd1;
    localparam logic [1:0] GRIP_PLACE  = 2'd2;
    localparam logic [1:0] ARM_DOWN    = 2'd1;
    localparam logic [1:0] ARM_UP      = 2'd2;

    localparam logic signed [31:0] NO_MOVE = 32'sh7FFF_FFFF;
    localparam logic signed [33:0] TGT_MAX = 34'sd2147483646;
    localparam logic signed [33:0] TGT_MIN = -34'sd2147483648;

    localparam logic [7:0]  RST_DEBOUNCE  = 8'd20;
    localparam logic [11:0] RST_ADC_LOW   = 12'd1000;
    localparam logic [11:0] RST_ADC_HIGH  = 12'd3000;
    localparam logic [15:0] RST_FREE_DUTY = 16'd1000;
    localparam logic [30:0] RST_STEP_SIZE = 31'd5719;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [11:0] adc_low_threshold;
        logic [11:0] adc_high_threshold;
        logic [15:0] free_duty;
        logic [30:0] step_size;
    } cfg_t;

    // Packed from the top down, so the first field lands in the highest bits.
    typedef struct packed {
        logic               estop_flag;
        logic signed [31:0] position_now;
        logic [11:0]        stick_sample;
        logic [4:0]         buttons_raw;
        logic               manual_active;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] move_target;
        logic               point_mode;
        logic               run_clear;
        logic               control_reset;
        logic [1:0]         arm_cmd;
        logic [1:0]         gripper_seq;
        logic [1:0]         home_cmd;
        logic               estop_out;
        logic               dir_ccw;
        logic [15:0]        pwm_duty;
        logic               duty_write;
        logic               driving;
    } result_t;

    localparam int IN_BITS  = $bits(in_item_t);
    localparam int OUT_BITS = $bits(result_t);

endpackage

`default_nettype wire

// ===== src/jmmc_db_lane.sv =====
// One button debouncer lane: raw history, hold counter and stable level.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module jmmc_db_lane (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic       raw,
    input  wire logic [7:0] ticks,
    output logic            press
);

    logic       prev_reg,   prev_next;
    logic [7:0] count_reg,  count_next;
    logic       stable_reg, stable_next;

    always_comb
    begin
        prev_next   = raw;
        count_next  = count_reg;
        stable_next = stable_reg;
        press       = 1'b0;
        if (raw == prev_reg)
        begin
            if (count_reg < ticks)
            begin
                count_next = count_reg + 8'd1;
            end
            else if (raw != stable_reg)
            begin
                stable_next = raw;
                press       = raw;
            end
        end
        else
        begin
            count_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b0;
            count_reg  <= 8'd0;
            stable_reg <= 1'b0;
        end
        else if (advance)
        begin
            prev_reg   <= prev_next;
            count_reg  <= count_next;
            stable_reg <= stable_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/jmmc_cmd_merge.sv =====
// Merges the debounced press edges with the stick sample into one result,
// and keeps the mode and toggle state. Depends on jmmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jmmc_cmd_merge (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 accept,
    input  wire jmmc_pkg::in_item_t                   item,
    input  wire logic [jmmc_pkg::CMD_BUTTONS-1:0]     presses,
    input  wire jmmc_pkg::cfg_t                       cfg,
    output jmmc_pkg::result_t                         result
);

    logic mode_reg,    mode_next;
    logic grip_reg,    grip_next;
    logic arm_reg,     arm_next;
    logic neutral_reg, neutral_next;
    logic drv_reg,     drv_next;

    logic [11:0]        sample;
    logic               ccw;
    logic               cw;
    logic               active;
    logic signed [33:0] pos_ext;
    logic signed [33:0] step_ext;
    logic signed [33:0] tgt_sum;
    logic signed [31:0] tgt_sat;
    logic               proceed;

    assign sample   = item.stick_sample & jmmc_pkg::SAMPLE_MASK;
    assign ccw      = sample < cfg.adc_low_threshold;
    assign cw       = sample > cfg.adc_high_threshold;
    assign active   = ccw || cw;
    assign pos_ext  = 34'(item.position_now);
    assign step_ext = $signed({3'b000, cfg.step_size});
    assign tgt_sum  = ccw ? (pos_ext - step_ext) : (pos_ext + step_ext);

    always_comb
    begin
        if (tgt_sum > jmmc_pkg::TGT_MAX)
        begin
            tgt_sat = jmmc_pkg::TGT_MAX[31:0];
        end
        else if (tgt_sum < jmmc_pkg::TGT_MIN)
        begin
            tgt_sat = jmmc_pkg::TGT_MIN[31:0];
        end
        else
        begin
            tgt_sat = tgt_sum[31:0];
        end
    end

    always_comb
    begin
        result             = '0;
        result.estop_out   = item.estop_flag;
        result.move_target = jmmc_pkg::NO_MOVE;
        mode_next          = mode_reg;
        grip_next          = grip_reg;
        arm_next           = arm_reg;
        neutral_next       = neutral_reg;
        drv_next           = drv_reg;
        proceed            = item.manual_active;

        if (item.manual_active)
        begin
            if (presses[jmmc_pkg::BTN_A])
            begin
                result.control_reset = 1'b1;
                drv_next             = 1'b0;
                if (!item.estop_flag)
                begin
                    result.duty_write = 1'b1;
                    result.estop_out  = 1'b1;
                    result.run_clear  = 1'b1;
                end
                else
                begin
                    result.estop_out = 1'b0;
                    result.home_cmd  = jmmc_pkg::HOME_SENSOR;
                end
            end
            if (result.estop_out || (presses[jmmc_pkg::BTN_A] && item.estop_flag))
            begin
                proceed = 1'b0;
            end
        end

        if (proceed)
        begin
            if (presses[jmmc_pkg::BTN_B])
            begin
                result.gripper_seq = grip_reg ? jmmc_pkg::GRIP_PLACE : jmmc_pkg::GRIP_PICK;
                grip_next          = !grip_reg;
            end
            if (presses[jmmc_pkg::BTN_C])
            begin
                result.home_cmd      = jmmc_pkg::HOME_SET;
                result.control_reset = 1'b1;
                neutral_next         = 1'b1;
                result.move_target   = '0;
            end
            if (presses[jmmc_pkg::BTN_D])
            begin
                result.arm_cmd = arm_reg ? jmmc_pkg::ARM_UP : jmmc_pkg::ARM_DOWN;
                arm_next       = !arm_reg;
            end
            if (presses[jmmc_pkg::BTN_K])
            begin
                if (!mode_reg)
                begin
                    mode_next          = 1'b1;
                    neutral_next       = 1'b1;
                    result.move_target = item.position_now;
                end
                else
                begin
                    mode_next = 1'b0;
                end
                result.control_reset = 1'b1;
                result.run_clear     = 1'b1;
                drv_next             = 1'b0;
            end

            if (!mode_next)
            begin
                if (active)
                begin
                    result.run_clear  = 1'b1;
                    result.dir_ccw    = ccw;
                    result.duty_write = 1'b1;
                    result.pwm_duty   = cfg.free_duty;
                    drv_next          = 1'b1;
                    result.driving    = 1'b1;
                end
                else if (drv_next)
                begin
                    result.duty_write    = 1'b1;
                    result.control_reset = 1'b1;
                    drv_next             = 1'b0;
                end
            end
            else
            begin
                if (active && neutral_next)
                begin
                    neutral_next       = 1'b0;
                    result.move_target = tgt_sat;
                end
                else if (!active)
                begin
                    neutral_next = 1'b1;
                end
                result.run_clear = 1'b1;
                result.driving   = 1'b1;
            end
        end

        result.point_mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            grip_reg    <= 1'b0;
            arm_reg     <= 1'b0;
            neutral_reg <= 1'b1;
            drv_reg     <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            grip_reg    <= grip_next;
            arm_reg     <= arm_next;
            neutral_reg <= neutral_next;
            drv_reg     <= drv_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/jmmc_out_buf.sv =====
// Two-entry output buffer: an output register backed by a skid register.
// Depends on jmmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jmmc_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire jmmc_pkg::result_t load_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output jmmc_pkg::result_t      out_data,
    output logic                   full
);

    logic              valid_reg;
    logic              skid_valid_reg;
    jmmc_pkg::result_t data_reg;
    jmmc_pkg::result_t skid_data_reg;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign full      = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !valid_reg)
        begin
            if (skid_valid_reg)
            begin
                valid_reg      <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                valid_reg <= load;
            end
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !valid_reg)
        begin
            data_reg <= skid_valid_reg ? skid_data_reg : load_data;
        end
        else if (load)
        begin
            skid_data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/joystick_manual_mode_controller_unit.sv =====
// Top level of the joystick manual-mode controller: stream ports, register
// port, debouncer lanes, command merge and output buffer. Depends on jmmc_pkg,
// jmmc_db_lane, jmmc_cmd_merge and jmmc_out_buf.
//
// Each input request carries one 1 ms tick and yields exactly one result
// request, registered in the output buffer. One tick is accepted on every
// clock cycle while s_axis_tready is high; the debouncer lanes and the
// command merge settle within that cycle. A two-entry output buffer lets
// the block keep accepting while one result waits, and s_axis_tready drops
// only when both entries are full. Registers live at byte addresses 0, 4, 8,
// 12 and 16 and should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module joystick_manual_mode_controller_unit #(
    parameter int BUTTON_COUNT = jmmc_pkg::BUTTON_COUNT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // From bit 0: manual_active, buttons_raw[4:0], stick_sample[11:0],
    // position_now[31:0], estop_flag, zero fill.
    input  wire logic [jmmc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // From bit 0: driving, duty_write, pwm_duty[15:0], dir_ccw, estop_out,
    // home_cmd[1:0], gripper_seq[1:0], arm_cmd[1:0], control_reset, run_clear,
    // point_mode, move_target[31:0], zero fill.
    output logic [jmmc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [jmmc_pkg::ADDR_BITS-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int LANES = (BUTTON_COUNT < jmmc_pkg::CMD_BUTTONS) ?
                           BUTTON_COUNT : jmmc_pkg::CMD_BUTTONS;

    jmmc_pkg::cfg_t                     cfg_reg;
    jmmc_pkg::reg_index_t               reg_sel;
    jmmc_pkg::in_item_t                 item;
    jmmc_pkg::result_t                  result;
    jmmc_pkg::result_t                  out_item;
    logic [jmmc_pkg::CMD_BUTTONS-1:0]   presses;
    logic                               accept;
    logic                               lane_advance;
    logic                               buf_full;
    logic                               cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = jmmc_pkg::reg_index_t'(paddr[jmmc_pkg::ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            jmmc_pkg::REG_DEBOUNCE:  prdata = {24'd0, cfg_reg.debounce_ticks};
            jmmc_pkg::REG_ADC_LOW:   prdata = {20'd0, cfg_reg.adc_low_threshold};
            jmmc_pkg::REG_ADC_HIGH:  prdata = {20'd0, cfg_reg.adc_high_threshold};
            jmmc_pkg::REG_FREE_DUTY: prdata = {16'd0, cfg_reg.free_duty};
            jmmc_pkg::REG_STEP_SIZE: prdata = {1'b0, cfg_reg.step_size};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= jmmc_pkg::RST_DEBOUNCE;
            cfg_reg.adc_low_threshold  <= jmmc_pkg::RST_ADC_LOW;
            cfg_reg.adc_high_threshold <= jmmc_pkg::RST_ADC_HIGH;
            cfg_reg.free_duty          <= jmmc_pkg::RST_FREE_DUTY;
            cfg_reg.step_size          <= jmmc_pkg::RST_STEP_SIZE;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                jmmc_pkg::REG_DEBOUNCE:  cfg_reg.debounce_ticks     <= pwdata[7:0];
                jmmc_pkg::REG_ADC_LOW:   cfg_reg.adc_low_threshold  <= pwdata[11:0];
                jmmc_pkg::REG_ADC_HIGH:  cfg_reg.adc_high_threshold <= pwdata[11:0];
                jmmc_pkg::REG_FREE_DUTY: cfg_reg.free_duty          <= pwdata[15:0];
                jmmc_pkg::REG_STEP_SIZE: cfg_reg.step_size          <= pwdata[30:0];
                default:                 cfg_reg.debounce_ticks     <= cfg_reg.debounce_ticks;
            endcase
        end
    end

    assign item          = jmmc_pkg::in_item_t'(s_axis_tdata[jmmc_pkg::IN_BITS-1:0]);
    assign s_axis_tready = !buf_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign lane_advance  = accept && item.manual_active;

    for (genvar i = 0; i < jmmc_pkg::CMD_BUTTONS; i++)
    begin : g_lane
        if (i < LANES)
        begin : g_used
            jmmc_db_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (lane_advance),
                .raw     (item.buttons_raw[i]),
                .ticks   (cfg_reg.debounce_ticks),
                .press   (presses[i])
            );
        end
        else
        begin : g_absent
            assign presses[i] = 1'b0;
        end
    end

    jmmc_cmd_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .presses (presses),
        .cfg     (cfg_reg),
        .result  (result)
    );

    jmmc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_item),
        .full      (buf_full)
    );

    assign m_axis_tdata = {{(jmmc_pkg::OUT_TDATA_W - jmmc_pkg::OUT_BITS){1'b0}}, out_item};

    // The skid entry can only hold a result while the output entry holds one.
    a_full_implies_valid : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // A nonzero compare value is only ever sent while driving in free mode.
    a_duty_only_driving : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_item.pwm_duty != 16'd0) |->
        (out_item.driving && out_item.duty_write && !out_item.estop_out))
        else $error("nonzero duty outside free drive");

    // The joystick never owns the motor while the emergency stop is set.
    a_no_drive_in_estop : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_item.driving) |-> !out_item.estop_out)
        else $error("driving with emergency stop set");

endmodule

`default_nettype wire

// ===== verif/tb_joystick_manual_mode_controller_unit.sv =====
// Self-checking testbench for joystick_manual_mode_controller_unit: drives ticks on the
// input stream and register writes on the APB port, and checks every result against a
// cycle-free model or a directed expected value. Depends on jmmc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_joystick_manual_mode_controller_unit;

    localparam int STALL_LIMIT = 5000;
    localparam logic [11:0] MID = 12'd2048;

    typedef struct {
        bit                   is_cfg;
        jmmc_pkg::reg_index_t reg_id;
        logic [31:0]          reg_val;
        jmmc_pkg::in_item_t   tick;
        bit                   has_res;
        jmmc_pkg::result_t    res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [jmmc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [jmmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [jmmc_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Model configuration and state.
    logic [7:0]  dbt_cfg = jmmc_pkg::RST_DEBOUNCE;
    logic [11:0] low_cfg = jmmc_pkg::RST_ADC_LOW;
    logic [11:0] high_cfg = jmmc_pkg::RST_ADC_HIGH;
    logic [15:0] duty_cfg = jmmc_pkg::RST_FREE_DUTY;
    logic [30:0] step_cfg = jmmc_pkg::RST_STEP_SIZE;
    logic        btn_prev[jmmc_pkg::CMD_BUTTONS];
    logic [7:0]  hold_cnt[jmmc_pkg::CMD_BUTTONS];
    logic        settled_lvl[jmmc_pkg::CMD_BUTTONS];
    logic        in_point_mode = 1'b0;
    logic [31:0] point_target = '0;
    logic        next_is_place = 1'b0;
    logic        next_is_up = 1'b0;
    logic        stick_was_neutral = 1'b1;
    logic        free_was_driving = 1'b0;

    jmmc_pkg::result_t pending_results[$];
    dir_row_t    dir_rows[$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    int unsigned src_idle = 0;
    int unsigned dst_idle = 0;
    logic        last_estop = 1'b0;

    logic [4:0]  gen_btn_level = '0;
    int          gen_btn_hold = 0;
    logic [11:0] gen_stick = MID;
    int          gen_stick_hold = 0;
    logic [31:0] gen_pos = '0;

    joystick_manual_mode_controller_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        for (int i = 0; i < jmmc_pkg::CMD_BUTTONS; i++)
        begin
            btn_prev[i] = 1'b0;
            hold_cnt[i] = '0;
            settled_lvl[i] = 1'b0;
        end
    end

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic jmmc_pkg::result_t tick_outputs(input jmmc_pkg::in_item_t it);
        jmmc_pkg::result_t r;
        logic [4:0] edges;
        logic [11:0] smp;
        logic ccw, cw, active, go, lvl;
        logic signed [33:0] pos_w, step_w, t;
        int i;
        r = '0;
        r.move_target = jmmc_pkg::NO_MOVE;
        r.estop_out = it.estop_flag;
        go = it.manual_active;
        if (go)
        begin
            edges = '0;
            for (i = 0; i < jmmc_pkg::BUTTON_COUNT_DEF; i++)
            begin
                lvl = it.buttons_raw[i];
                if (lvl == btn_prev[i])
                begin
                    if (hold_cnt[i] < dbt_cfg)
                        hold_cnt[i] = hold_cnt[i] + 8'd1;
                    else if (lvl != settled_lvl[i])
                    begin
                        settled_lvl[i] = lvl;
                        edges[i] = lvl;
                    end
                end
                else
                    hold_cnt[i] = '0;
                btn_prev[i] = lvl;
            end
            if (edges[jmmc_pkg::BTN_A])
            begin
                r.control_reset = 1'b1;
                free_was_driving = 1'b0;
                if (!it.estop_flag)
                begin
                    r.duty_write = 1'b1;
                    r.estop_out = 1'b1;
                    r.run_clear = 1'b1;
                end
                else
                begin
                    r.estop_out = 1'b0;
                    r.home_cmd = jmmc_pkg::HOME_SENSOR;
                    go = 1'b0;
                end
            end
            if (go && r.estop_out)
                go = 1'b0;
            if (go)
            begin
                if (edges[jmmc_pkg::BTN_B])
                begin
                    r.gripper_seq = next_is_place ? jmmc_pkg::GRIP_PLACE : jmmc_pkg::GRIP_PICK;
                    next_is_place = ~next_is_place;
                end
                if (edges[jmmc_pkg::BTN_C])
                begin
                    r.home_cmd = jmmc_pkg::HOME_SET;
                    r.control_reset = 1'b1;
                    point_target = '0;
                    stick_was_neutral = 1'b1;
                    r.move_target = '0;
                end
                if (edges[jmmc_pkg::BTN_D])
                begin
                    r.arm_cmd = next_is_up ? jmmc_pkg::ARM_UP : jmmc_pkg::ARM_DOWN;
                    next_is_up = ~next_is_up;
                end
                if (edges[jmmc_pkg::BTN_K])
                begin
                    if (!in_point_mode)
                    begin
                        in_point_mode = 1'b1;
                        point_target = it.position_now;
                        stick_was_neutral = 1'b1;
                        r.move_target = it.position_now;
                    end
                    else
                        in_point_mode = 1'b0;
                    r.control_reset = 1'b1;
                    r.run_clear = 1'b1;
                    free_was_driving = 1'b0;
                end
                smp = it.stick_sample & jmmc_pkg::SAMPLE_MASK;
                ccw = smp < low_cfg;
                cw = smp > high_cfg;
                active = ccw || cw;
                if (!in_point_mode)
                begin
                    if (active)
                    begin
                        r.run_clear = 1'b1;
                        r.dir_ccw = ccw;
                        r.duty_write = 1'b1;
                        r.pwm_duty = duty_cfg;
                        free_was_driving = 1'b1;
                        r.driving = 1'b1;
                    end
                    else if (free_was_driving)
                    begin
                        r.duty_write = 1'b1;
                        r.control_reset = 1'b1;
                        free_was_driving = 1'b0;
                    end
                end
                else
                begin
                    if (!active)
                        stick_was_neutral = 1'b1;
                    if (active && stick_was_neutral)
                    begin
                        stick_was_neutral = 1'b0;
                        pos_w = {{2{it.position_now[31]}}, it.position_now};
                        step_w = {3'b000, step_cfg};
                        t = ccw ? pos_w - step_w : pos_w + step_w;
                        if (t > jmmc_pkg::TGT_MAX)
                            t = jmmc_pkg::TGT_MAX;
                        if (t < jmmc_pkg::TGT_MIN)
                            t = jmmc_pkg::TGT_MIN;
                        point_target = t[31:0];
                        r.move_target = t[31:0];
                    end
                    r.run_clear = 1'b1;
                    r.driving = 1'b1;
                end
            end
        end
        r.point_mode = in_point_mode;
        return r;
    endfunction

    function automatic jmmc_pkg::result_t mk_res(input logic drv, input logic dw,
                                                 input logic [15:0] pwm, input logic dir,
                                                 input logic est, input logic [1:0] home,
                                                 input logic [1:0] grip, input logic [1:0] arm,
                                                 input logic creset, input logic rclear,
                                                 input logic pmode, input logic [31:0] move);
        jmmc_pkg::result_t r;
        r.driving = drv;
        r.duty_write = dw;
        r.pwm_duty = pwm;
        r.dir_ccw = dir;
        r.estop_out = est;
        r.home_cmd = home;
        r.gripper_seq = grip;
        r.arm_cmd = arm;
        r.control_reset = creset;
        r.run_clear = rclear;
        r.point_mode = pmode;
        r.move_target = move;
        return r;
    endfunction

    function automatic dir_row_t tick_row(input logic man, input logic [4:0] btn,
                                          input logic [11:0] smp, input logic [31:0] pos,
                                          input logic est);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.reg_id = jmmc_pkg::REG_DEBOUNCE;
        row.reg_val = '0;
        row.tick.manual_active = man;
        row.tick.buttons_raw = btn;
        row.tick.stick_sample = smp;
        row.tick.position_now = pos;
        row.tick.estop_flag = est;
        row.has_res = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic dir_row_t checked(input dir_row_t row, input jmmc_pkg::result_t res);
        dir_row_t r;
        r = row;
        r.has_res = 1'b1;
        r.res = res;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input jmmc_pkg::reg_index_t idx,
                                         input logic [31:0] val);
        dir_row_t row;
        row = tick_row(1'b0, '0, '0, '0, 1'b0);
        row.is_cfg = 1'b1;
        row.reg_id = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic bit field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatch_count < 10)
                $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic write_reg(input jmmc_pkg::reg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            jmmc_pkg::REG_DEBOUNCE:  dbt_cfg = val[7:0];
            jmmc_pkg::REG_ADC_LOW:   low_cfg = val[11:0];
            jmmc_pkg::REG_ADC_HIGH:  high_cfg = val[11:0];
            jmmc_pkg::REG_FREE_DUTY: duty_cfg = val[15:0];
            jmmc_pkg::REG_STEP_SIZE: step_cfg = val[30:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_tick(input jmmc_pkg::in_item_t it, input bit typed,
                             input jmmc_pkg::result_t typed_res);
        jmmc_pkg::result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {{(jmmc_pkg::IN_TDATA_W - jmmc_pkg::IN_BITS){1'b0}}, it};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = tick_outputs(it);
        last_estop = predicted.estop_out;
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic run_phase(input logic [7:0] dbt, input logic [11:0] lo, input logic [11:0] hi,
                             input logic [15:0] duty, input logic [30:0] step,
                             input int unsigned sidle, input int unsigned didle, input int n);
        int k;
        int roll;
        jmmc_pkg::in_item_t it;
        wait_idle();
        write_reg(jmmc_pkg::REG_DEBOUNCE, dbt);
        write_reg(jmmc_pkg::REG_ADC_LOW, lo);
        write_reg(jmmc_pkg::REG_ADC_HIGH, hi);
        write_reg(jmmc_pkg::REG_FREE_DUTY, duty);
        write_reg(jmmc_pkg::REG_STEP_SIZE, step);
        src_idle = sidle;
        dst_idle = didle;
        for (k = 0; k < n; k++)
        begin
            // Mostly clean presses and releases held past the debounce time, some bounce.
            if (gen_btn_hold == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    if (gen_btn_level != 0)
                        gen_btn_level = '0;
                    else if ($urandom_range(0, 4) == 0)
                        gen_btn_level = 5'($urandom);
                    else
                        gen_btn_level = 5'(1 << $urandom_range(0, 4));
                    gen_btn_hold = int'(dbt_cfg) + 2 + $urandom_range(0, 4);
                end
                else if (roll < 88)
                begin
                    gen_btn_level = 5'($urandom);
                    gen_btn_hold = $urandom_range(1, int'(dbt_cfg) + 1);
                end
                else
                begin
                    gen_btn_level = 5'($urandom);
                    gen_btn_hold = int'(dbt_cfg) + 2 + $urandom_range(0, 12);
                end
            end
            gen_btn_hold--;
            if (gen_stick_hold == 0)
            begin
                case ($urandom_range(0, 7))
                    0, 1: gen_stick = MID;
                    2: gen_stick = 12'h000;
                    3: gen_stick = 12'hFFF;
                    4: gen_stick = 12'(low_cfg + $urandom_range(0, 2) - 1);
                    5: gen_stick = 12'(high_cfg + $urandom_range(0, 2) - 1);
                    default: gen_stick = 12'($urandom);
                endcase
                gen_stick_hold = $urandom_range(1, 8);
            end
            gen_stick_hold--;
            case ($urandom_range(0, 15))
                0: gen_pos = 32'h7FFF_FFFF;
                1: gen_pos = 32'h8000_0000;
                2: gen_pos = $urandom;
                default: gen_pos = gen_pos + 32'($urandom_range(0, 2000)) - 32'd1000;
            endcase
            it.manual_active = ($urandom_range(0, 19) != 0);
            it.buttons_raw = gen_btn_level;
            it.stick_sample = gen_stick;
            it.position_now = gen_pos;
            it.estop_flag = ($urandom_range(0, 11) == 0) ? 1'($urandom) : last_estop;
            send_tick(it, 1'b0, '0);
        end
    endtask

    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(0, 99) >= dst_idle);
    end

    always @(posedge clk)
    begin
        jmmc_pkg::result_t got;
        jmmc_pkg::result_t want;
        bit bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = jmmc_pkg::result_t'(m_axis_tdata[jmmc_pkg::OUT_BITS-1:0]);
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t ns: result %0h with no tick pending", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                bad = 1'b0;
                bad |= field_diff("driving", want.driving, got.driving);
                bad |= field_diff("duty_write", want.duty_write, got.duty_write);
                bad |= field_diff("pwm_duty", want.pwm_duty, got.pwm_duty);
                bad |= field_diff("dir_ccw", want.dir_ccw, got.dir_ccw);
                bad |= field_diff("estop_out", want.estop_out, got.estop_out);
                bad |= field_diff("home_cmd", want.home_cmd, got.home_cmd);
                bad |= field_diff("gripper_seq", want.gripper_seq, got.gripper_seq);
                bad |= field_diff("arm_cmd", want.arm_cmd, got.arm_cmd);
                bad |= field_diff("control_reset", want.control_reset, got.control_reset);
                bad |= field_diff("run_clear", want.run_clear, got.run_clear);
                bad |= field_diff("point_mode", want.point_mode, got.point_mode);
                bad |= field_diff("move_target", want.move_target, got.move_target);
                if (bad)
                    mismatch_count++;
            end
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows.push_back(checked(tick_row(1'b0, 5'b00000, 12'h000, 32'h0, 1'b1),
            mk_res(0, 0, 0, 0, 1, jmmc_pkg::HOME_NONE, 0, 0, 0, 0, 0, jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b00000, MID, 32'h0, 1'b0),
            mk_res(0, 0, 0, 0, 0, jmmc_pkg::HOME_NONE, 0, 0, 0, 0, 0, jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b00000, 12'h000, 32'h0, 1'b0),
            mk_res(1, 1, jmmc_pkg::RST_FREE_DUTY, 1, 0, jmmc_pkg::HOME_NONE, 0, 0, 0, 1, 0,
                   jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b00000, 12'hFFF, 32'h0, 1'b0),
            mk_res(1, 1, jmmc_pkg::RST_FREE_DUTY, 0, 0, jmmc_pkg::HOME_NONE, 0, 0, 0, 1, 0,
                   jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b00000, MID, 32'h0, 1'b0),
            mk_res(0, 1, 0, 0, 0, jmmc_pkg::HOME_NONE, 0, 0, 1, 0, 0, jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(cfg_row(jmmc_pkg::REG_DEBOUNCE, 32'd0));
        dir_rows.push_back(cfg_row(jmmc_pkg::REG_FREE_DUTY, 32'hFFFF));
        dir_rows.push_back(tick_row(1'b1, 5'b00001, MID, 32'h0, 1'b0));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b00001, MID, 32'h0, 1'b0),
            mk_res(0, 1, 0, 0, 1, jmmc_pkg::HOME_NONE, 0, 0, 1, 1, 0, jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(tick_row(1'b1, 5'b00000, MID, 32'h0, 1'b1));
        dir_rows.push_back(tick_row(1'b1, 5'b00000, 12'h000, 32'h0, 1'b1));
        dir_rows.push_back(tick_row(1'b1, 5'b00001, MID, 32'h0, 1'b1));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b00001, MID, 32'h0, 1'b1),
            mk_res(0, 0, 0, 0, 0, jmmc_pkg::HOME_SENSOR, 0, 0, 1, 0, 0, jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(tick_row(1'b1, 5'b00000, MID, 32'h0, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 5'b00000, 12'hFFF, 32'h0, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 5'b01010, MID, 32'h0, 1'b0));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b01010, MID, 32'h0, 1'b0),
            mk_res(0, 0, 0, 0, 0, jmmc_pkg::HOME_NONE, jmmc_pkg::GRIP_PICK, jmmc_pkg::ARM_DOWN,
                   0, 0, 0, jmmc_pkg::NO_MOVE)));
        dir_rows.push_back(tick_row(1'b1, 5'b00000, MID, 32'h0, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 5'b00000, MID, 32'h0, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 5'b10100, MID, 32'h0001_0000, 1'b0));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b10100, MID, 32'h0001_0000, 1'b0),
            mk_res(1, 0, 0, 0, 0, jmmc_pkg::HOME_SET, 0, 0, 1, 1, 1, 32'h0001_0000)));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b10100, 12'hFFF, 32'h7FFF_FFFF, 1'b0),
            mk_res(1, 0, 0, 0, 0, jmmc_pkg::HOME_NONE, 0, 0, 0, 1, 1, 32'h7FFF_FFFE)));
        dir_rows.push_back(tick_row(1'b1, 5'b10100, MID, 32'h7FFF_FFFF, 1'b0));
        dir_rows.push_back(checked(tick_row(1'b1, 5'b10100, 12'h000, 32'h8000_0000, 1'b0),
            mk_res(1, 0, 0, 0, 0, jmmc_pkg::HOME_NONE, 0, 0, 0, 1, 1, 32'h8000_0000)));

        src_idle = 16;
        dst_idle = 71;
        foreach (dir_rows[n])
        begin
            if (dir_rows[n].is_cfg)
            begin
                wait_idle();
                write_reg(dir_rows[n].reg_id, dir_rows[n].reg_val);
            end
            else
                send_tick(dir_rows[n].tick, dir_rows[n].has_res, dir_rows[n].res);
        end

        run_phase(8'd1, 12'd1000, 12'd3000, 16'($urandom), 31'd5719, 16, 71, 300);
        run_phase(8'd0, 12'd0, 12'd4095, 16'hFFFF, 31'h7FFF_FFFF, 16, 71, 200);
        run_phase(8'd2, 12'd3000, 12'd1000, 16'h0000, 31'd0, 71, 16, 300);
        run_phase(8'd255, 12'd4095, 12'd0, 16'd1234, 31'h7FFF_FFFF, 71, 16, 400);
        run_phase(8'd3, 12'($urandom_range(500, 2000)), 12'($urandom_range(2000, 3500)),
                  16'($urandom), 31'($urandom), 0, 0, 300);
        run_phase(8'($urandom_range(0, 5)), jmmc_pkg::RST_ADC_LOW, jmmc_pkg::RST_ADC_HIGH,
                  jmmc_pkg::RST_FREE_DUTY, jmmc_pkg::RST_STEP_SIZE, 0, 0, 200);

        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/jmmc_pkg.sv
src/jmmc_db_lane.sv
src/jmmc_cmd_merge.sv
src/jmmc_out_buf.sv
src/joystick_manual_mode_controller_unit.sv
verif/tb_joystick_manual_mode_controller_unit.sv
